// ===== sv/amiu_pkg.sv =====
// Shared types and constants for the affine 3x4 matrix inverse unit.
// Used by every module of the block; depends on nothing else.
package amiu_pkg;

  localparam int DATA_W        = 32;   // width of every Q-format entry
  localparam int ADJ_W         = 65;   // exact adjugate entry, signed
  localparam int ACC_W         = 100;  // determinant and translation sums, signed
  localparam int QUO_W         = 33;   // quotient bits produced before rounding
  localparam int DEF_FRAC_BITS = 16;
  localparam int Q_DEPTH       = 2;
  localparam int N_ADJ         = 9;
  localparam int N_LANES       = 4;    // three linear columns and the translation

  localparam logic [DATA_W-1:0] LIMIT_RESET = 32'd281;
  localparam logic [DATA_W-1:0] MAX_POS     = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MIN_MAG     = 32'h8000_0000;
  localparam logic [1:0]        ROW_LAST    = 2'd2;
  localparam logic [2:0]        MUL_STEPS   = 3'd6;  // three terms, two halves each

  // Adjugate entry k = m[PA]*m[PB] - m[NA]*m[NB], matrix row-major.
  localparam int ADJ_PA [N_ADJ] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int ADJ_PB [N_ADJ] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int ADJ_NA [N_ADJ] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int ADJ_NB [N_ADJ] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  // One classified transform waiting for the back end.
  typedef struct packed {
    logic [N_ADJ-1:0][ADJ_W-1:0] adj;
    logic [2:0][DATA_W-1:0]      row0;
    logic [2:0][DATA_W-1:0]      shift;
  } job_t;

endpackage

// ===== sv/amiu_front.sv =====
// Front end: accepts a transform beat and forms its exact adjugate.
// Depends on amiu_pkg; feeds amiu_queue.
module amiu_front import amiu_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [N_ADJ-1:0][DATA_W-1:0] lin,
  input  logic [2:0][DATA_W-1:0]      shift,
  output logic                        push,
  output job_t                        push_job,
  input  logic                        q_full
);

  logic                     f_v_r;
  logic signed [63:0]       pp_r [N_ADJ];
  logic signed [63:0]       pn_r [N_ADJ];
  logic [2:0][DATA_W-1:0]   row0_r;
  logic [2:0][DATA_W-1:0]   shift_r;
  logic                     go;

  // The product stage advances whenever the queue can take its contents.
  assign go       = !f_v_r || !q_full;
  assign in_stall = !go;
  assign push     = f_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (go) begin
      f_v_r <= in_valid;
    end
  end

  // Eighteen independent 32x32 products, one pair per adjugate entry.
  always_ff @(posedge clk) begin
    if (go && in_valid) begin
      for (int k = 0; k < N_ADJ; k++) begin
        pp_r[k] <= $signed(lin[ADJ_PA[k]]) * $signed(lin[ADJ_PB[k]]);
        pn_r[k] <= $signed(lin[ADJ_NA[k]]) * $signed(lin[ADJ_NB[k]]);
      end
      row0_r  <= lin[2:0];
      shift_r <= shift;
    end
  end

  // The differences go straight into the queue entry.
  always_comb begin
    for (int k = 0; k < N_ADJ; k++) begin
      push_job.adj[k] = ADJ_W'(pp_r[k]) - ADJ_W'(pn_r[k]);
    end
    push_job.row0  = row0_r;
    push_job.shift = shift_r;
  end

endmodule

// ===== sv/amiu_queue.sv =====
// Short queue of classified transforms between front and back ends.
// Depends on amiu_pkg for the entry type and depth.
module amiu_queue import amiu_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic q_full,
  input  logic pop,
  output logic q_valid,
  output job_t head
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  job_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;

  assign q_full  = (cnt_r == CNT_W'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign head    = mem_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

endmodule

// ===== sv/amiu_div.sv =====
// Restoring divider: rounded, saturated 32-bit quotient of two magnitudes.
// Depends on amiu_pkg; one bit per cycle, instantiated per lane by amiu_back.
module amiu_div import amiu_pkg::*; #(
  parameter int NUM_W = ACC_W + DEF_FRAC_BITS,
  parameter int DEN_W = ACC_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [NUM_W-1:0]  num_mag,
  input  logic              neg,
  input  logic [DEN_W-1:0]  den_mag,
  output logic              done,
  output logic [DATA_W-1:0] quo
);

  localparam int CW    = (NUM_W > DEN_W + QUO_W + 1) ? NUM_W : DEN_W + QUO_W + 1;
  localparam int CNT_W = $clog2(QUO_W + 2);

  logic [CW-1:0]     rem_r;
  logic [CW-1:0]     dsh_r;
  logic [DEN_W-1:0]  den_r;
  logic [QUO_W-1:0]  q_r;
  logic              ovf_r;
  logic              neg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              fin_r;
  logic              done_r;
  logic [DATA_W-1:0] quo_r;

  logic              ge;
  logic [CW-1:0]     diff;
  logic              rnd;
  logic [QUO_W:0]    q1;
  logic [QUO_W:0]    lim;
  logic              sat;
  logic [DATA_W-1:0] mag;

  assign ge   = rem_r >= dsh_r;
  assign diff = rem_r - dsh_r;

  // Round to nearest with ties away from zero, then clamp to the signed range.
  assign rnd  = {rem_r, 1'b0} >= (CW + 1)'(den_r);
  assign q1   = {1'b0, q_r} + (QUO_W + 1)'(rnd);
  assign lim  = (QUO_W + 1)'(neg_r ? MIN_MAG : MAX_POS);
  assign sat  = ovf_r || (q1 > lim);
  assign mag  = sat ? lim[DATA_W-1:0] : q1[DATA_W-1:0];

  assign done = done_r;
  assign quo  = quo_r;

  // Step counter: one overflow check, then one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(QUO_W + 1);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Shift-subtract datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= CW'(num_mag);
      dsh_r <= CW'(den_mag) << QUO_W;
      den_r <= den_mag;
      neg_r <= neg;
    end else if (cnt_r != '0) begin
      if (cnt_r == CNT_W'(QUO_W + 1)) begin
        ovf_r <= ge;
      end else begin
        if (ge) begin
          rem_r <= diff;
        end
        q_r <= {q_r[QUO_W-2:0], ge};
      end
      dsh_r <= dsh_r >> 1;
    end
    if (fin_r) begin
      quo_r <= neg_r ? DATA_W'(-mag) : mag;
    end
  end

endmodule

// ===== sv/amiu_back.sv =====
// Back end: determinant, singular test, per-row translation sum and divisions.
// Depends on amiu_pkg and amiu_div; drains amiu_queue and owns the result register.
module amiu_back import amiu_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  job_t              head,
  output logic              pop,
  input  logic [DATA_W-1:0] limit,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_row_index,
  output logic [DATA_W-1:0] out_inv_col0,
  output logic [DATA_W-1:0] out_inv_col1,
  output logic [DATA_W-1:0] out_inv_col2,
  output logic [DATA_W-1:0] out_inv_shift,
  output logic              out_invertible,
  output logic              out_last_row
);

  localparam int NUM_W = ACC_W + FRAC_BITS;
  localparam int DEN_W = ACC_W;
  localparam logic [DATA_W-1:0] ONE_FIX = DATA_W'(1) << FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DGO  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]              st_r;
  logic [2:0]              cnt_r;
  logic                    det_mode_r;
  logic [1:0]              row_r;
  logic                    ok_r;
  logic                    pv_r;
  logic                    ph_r;
  logic                    out_v_r;
  job_t                    job_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] det_r;
  logic signed [65:0]      prod_r;
  logic [1:0]              row_o_r;
  logic [DATA_W-1:0]       col0_r, col1_r, col2_r, shf_r;
  logic                    inv_o_r, last_o_r;

  logic [1:0]              term;
  logic [3:0]              aidx;
  logic [ADJ_W-1:0]        adj_sel;
  logic signed [32:0]      a_op, b_op;
  logic [DATA_W-1:0]       b_sel;
  logic signed [ACC_W-1:0] addend;
  logic [ACC_W-1:0]        amag;
  logic                    below_limit;
  logic                    load;
  logic                    start;
  logic                    clear;

  logic [NUM_W-1:0]        num_w  [N_LANES];
  logic                    neg_w  [N_LANES];
  logic [DATA_W-1:0]       quo_w  [N_LANES];
  logic [N_LANES-1:0]      done_w;
  logic [DEN_W-1:0]        den_w;

  // Multiply step operands: high signed half or low unsigned half of one adjugate entry.
  assign term    = cnt_r[2:1];
  assign aidx    = det_mode_r ? 4'(term) * 4'd3 : 4'(row_r) * 4'd3 + 4'(term);
  assign adj_sel = job_r.adj[aidx];
  assign a_op    = !cnt_r[0] ? $signed(adj_sel[ADJ_W-1:32]) : $signed({1'b0, adj_sel[31:0]});
  assign b_sel   = det_mode_r ? job_r.row0[term] : job_r.shift[term];
  assign b_op    = $signed({b_sel[DATA_W-1], b_sel});
  assign addend  = ph_r ? (ACC_W'(prod_r) <<< 32) : ACC_W'(prod_r);

  // Singular test on the finished determinant.
  assign amag        = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign below_limit = (amag[ACC_W-1:DATA_W] == '0) && (amag[DATA_W-1:0] <= limit);

  assign pop   = (st_r == S_IDLE) && q_valid;
  assign load  = (st_r == S_OUT) && (!out_v_r || !out_stall);
  assign start = (st_r == S_DGO);
  assign clear = pop || ((st_r == S_CHK) && !below_limit) ||
                 (load && ok_r && (row_r != ROW_LAST));

  // Division lanes: three linear columns of the row and its translation.
  assign den_w = det_r[ACC_W-1] ? DEN_W'(-det_r) : DEN_W'(det_r);

  for (genvar j = 0; j < N_LANES; j++) begin : g_lane
    if (j < 3) begin : g_col
      logic [ADJ_W-1:0] adj_e;
      logic [ADJ_W-1:0] adj_m;
      assign adj_e    = job_r.adj[4'(row_r) * 4'd3 + 4'(j)];
      assign adj_m    = adj_e[ADJ_W-1] ? ADJ_W'(-adj_e) : adj_e;
      assign num_w[j] = NUM_W'(adj_m) << (2 * FRAC_BITS);
      assign neg_w[j] = adj_e[ADJ_W-1] ^ det_r[ACC_W-1];
    end else begin : g_shift
      logic [ACC_W-1:0] s_m;
      assign s_m      = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
      assign num_w[j] = NUM_W'(s_m) << FRAC_BITS;
      assign neg_w[j] = (!acc_r[ACC_W-1] && (acc_r != '0)) ^ det_r[ACC_W-1];
    end
    amiu_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (start),
      .num_mag (num_w[j]),
      .neg     (neg_w[j]),
      .den_mag (den_w),
      .done    (done_w[j]),
      .quo     (quo_w[j])
    );
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      cnt_r      <= '0;
      det_mode_r <= 1'b0;
      row_r      <= '0;
      ok_r       <= 1'b0;
      pv_r       <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      pv_r <= (st_r == S_MUL) && (cnt_r < MUL_STEPS);
      if (load) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
      if (clear) begin
        cnt_r <= '0;
      end else if ((st_r == S_MUL) && (cnt_r < MUL_STEPS)) begin
        cnt_r <= cnt_r + 1'b1;
      end
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            det_mode_r <= 1'b1;
            row_r      <= '0;
            st_r       <= S_MUL;
          end
        end
        S_MUL: begin
          if (cnt_r == MUL_STEPS) begin
            st_r <= det_mode_r ? S_CHK : S_DGO;
          end
        end
        S_CHK: begin
          ok_r       <= !below_limit;
          det_mode_r <= 1'b0;
          st_r       <= below_limit ? S_OUT : S_MUL;
        end
        S_DGO: begin
          st_r <= S_DIV;
        end
        S_DIV: begin
          if (&done_w) begin
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (load) begin
            if (row_r == ROW_LAST) begin
              st_r <= S_IDLE;
            end else begin
              row_r <= row_r + 1'b1;
              st_r  <= ok_r ? S_MUL : S_OUT;
            end
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= head;
    end
    prod_r <= a_op * b_op;
    ph_r   <= !cnt_r[0];
    if (clear) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + addend;
    end
    if (st_r == S_CHK) begin
      det_r <= acc_r;
    end
    if (load) begin
      row_o_r  <= row_r;
      col0_r   <= ok_r ? quo_w[0] : ((row_r == 2'd0) ? ONE_FIX : '0);
      col1_r   <= ok_r ? quo_w[1] : ((row_r == 2'd1) ? ONE_FIX : '0);
      col2_r   <= ok_r ? quo_w[2] : ((row_r == 2'd2) ? ONE_FIX : '0);
      shf_r    <= ok_r ? quo_w[3] : '0;
      inv_o_r  <= ok_r;
      last_o_r <= (row_r == ROW_LAST);
    end
  end

  assign out_valid      = out_v_r;
  assign out_row_index  = row_o_r;
  assign out_inv_col0   = col0_r;
  assign out_inv_col1   = col1_r;
  assign out_inv_col2   = col2_r;
  assign out_inv_shift  = shf_r;
  assign out_invertible = inv_o_r;
  assign out_last_row   = last_o_r;

endmodule

// ===== sv/affine_matrix_inverse_unit.sv =====
// Affine 3x4 matrix inverse unit: top level with the threshold register.
// Depends on amiu_pkg, amiu_front, amiu_queue and amiu_back.
//
// Usage: one input beat on the in_ channel carries a whole transform, the
// 3x3 linear part and the translation, signed fixed point with FRAC_BITS
// fraction bits. Three result beats follow on the out_ channel, rows 0, 1
// and 2; last_row marks the third. A transform whose determinant magnitude
// is at or below the cfg_ threshold gives identity rows with invertible low.
// The front end forms the adjugate in a product register and parks it in a
// two-entry queue, so new beats are taken while the back end is busy.
// The back end first sums the determinant, then for each row sums the
// translation, starts four parallel bit-serial dividers, waits for the
// division and loads the output register; the dividers set the rate.
// It takes the next transform from the queue only once the last row loads.
// Reset empties the pipeline and queue and loads the threshold with 281.
// A stalled result holds in the output register; the back end waits on it
// while the front end keeps filling the queue until it is full.
module affine_matrix_inverse_unit import amiu_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [DATA_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] in_lin_r0c0,
  input  logic [DATA_W-1:0] in_lin_r0c1,
  input  logic [DATA_W-1:0] in_lin_r0c2,
  input  logic [DATA_W-1:0] in_lin_r1c0,
  input  logic [DATA_W-1:0] in_lin_r1c1,
  input  logic [DATA_W-1:0] in_lin_r1c2,
  input  logic [DATA_W-1:0] in_lin_r2c0,
  input  logic [DATA_W-1:0] in_lin_r2c1,
  input  logic [DATA_W-1:0] in_lin_r2c2,
  input  logic [DATA_W-1:0] in_shift_x,
  input  logic [DATA_W-1:0] in_shift_y,
  input  logic [DATA_W-1:0] in_shift_z,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_row_index,
  output logic [DATA_W-1:0] out_inv_col0,
  output logic [DATA_W-1:0] out_inv_col1,
  output logic [DATA_W-1:0] out_inv_col2,
  output logic [DATA_W-1:0] out_inv_shift,
  output logic              out_invertible,
  output logic              out_last_row
);

  localparam logic [DATA_W-1:0] ONE_FIX = DATA_W'(1) << FRAC_BITS;

  logic [DATA_W-1:0]         limit_r;
  logic [N_ADJ-1:0][DATA_W-1:0] lin_w;
  logic [2:0][DATA_W-1:0]    shift_w;
  logic                      push;
  job_t                      push_job;
  logic                      q_full;
  logic                      q_valid;
  logic                      pop;
  job_t                      head;

  // Singular threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  assign lin_w   = {in_lin_r2c2, in_lin_r2c1, in_lin_r2c0,
                    in_lin_r1c2, in_lin_r1c1, in_lin_r1c0,
                    in_lin_r0c2, in_lin_r0c1, in_lin_r0c0};
  assign shift_w = {in_shift_z, in_shift_y, in_shift_x};

  amiu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .lin      (lin_w),
    .shift    (shift_w),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  amiu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  amiu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .limit          (limit_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_index  (out_row_index),
    .out_inv_col0   (out_inv_col0),
    .out_inv_col1   (out_inv_col1),
    .out_inv_col2   (out_inv_col2),
    .out_inv_shift  (out_inv_shift),
    .out_invertible (out_invertible),
    .out_last_row   (out_last_row)
  );

`ifndef ASSERT_OFF
  // The last-row flag only ever marks row two.
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == ROW_LAST)))
    else $error("last_row does not match row_index");

  // A singular transform carries no translation.
  a_sing_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_invertible) |-> (out_inv_shift == '0))
    else $error("singular result with nonzero translation");

  // A singular transform gives the identity on its first row.
  a_sing_ident: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_invertible && (out_row_index == 2'd0)) |->
      ((out_inv_col0 == ONE_FIX) && (out_inv_col1 == '0) && (out_inv_col2 == '0)))
    else $error("singular row zero is not the identity");
`endif

endmodule
